### rtl/ordered_value_list_core_assert.svh
// Assertion macros shared by the ordered value list checker.
`ifndef ORDERED_VALUE_LIST_CORE_ASSERT_SVH
`define ORDERED_VALUE_LIST_CORE_ASSERT_SVH

// Same-cycle implication, reset masked.
`define OVL_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ordered value list assertion failed");

// Next-cycle implication, reset masked.
`define OVL_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ordered value list assertion failed");

`endif

### rtl/ovl_pkg.sv
// Shared types and constants for the ordered value list.
package ovl_pkg;

    localparam int OVL_CAPACITY = 32;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_AFTER = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_DUMP      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ELEMENT   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_RESULT
    } state_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] element;
        logic [5:0]         position;
        logic [6:0]         entry_count;
        logic               last;
    } res_t;

endpackage

### rtl/ovl_ram.sv
// Entry memory: one write port, one read port with registered read data.
module ovl_ram #(
    parameter int DEPTH = ovl_pkg::OVL_CAPACITY,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    import ovl_pkg::*;

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ovl_ctrl.sv
// Command sequencer: one pass over the entries with a shared compare unit.
module ovl_ctrl #(
    parameter int CAPACITY = ovl_pkg::OVL_CAPACITY,
    parameter int AW       = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [31:0]        mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  logic [31:0]        mem_rdata,
    output logic               res_valid,
    input  logic               res_ready,
    output ovl_pkg::res_t      res
);
    import ovl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_t         state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic           found_reg, found_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic           dv_reg, dv_next;
    logic [AW-1:0]  dp_reg, dp_next;
    logic [31:0]    target_reg, target_next;
    logic [31:0]    carry_reg, carry_next;
    status_t        rstat_reg, rstat_next;

    logic hit;
    logic hold;
    logic issue;
    logic is_ins;

    // shared 32-bit equality compare
    assign hit    = (mem_rdata == target_reg);
    assign is_ins = (cmd_reg == CMD_INS_FRONT) || (cmd_reg == CMD_INS_AFTER);
    // dump result waiting on the output: freeze the read pipe
    assign hold   = dv_reg && (cmd_reg == CMD_DUMP) && !res_ready;
    assign issue  = (state_reg == S_SCAN) && (rd_ptr_reg < count_reg) && !hold;

    assign mem_re    = issue;
    assign mem_raddr = rd_ptr_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_INS_FRONT;
            found_reg  <= 1'b0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            dv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            found_reg  <= found_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            dv_reg     <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dp_reg     <= dp_next;
        target_reg <= target_next;
        carry_reg  <= carry_next;
        rstat_reg  <= rstat_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        dv_next     = 1'b0;
        dp_next     = dp_reg;
        target_next = target_reg;
        carry_next  = carry_reg;
        rstat_next  = rstat_reg;
        in_stall    = 1'b1;
        mem_we      = 1'b0;
        mem_waddr   = dp_reg;
        mem_wdata   = carry_reg;
        res_valid   = 1'b0;
        res         = '{status: rstat_reg, element: '0, position: '0,
                        entry_count: 7'(count_reg), last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next    = cmd_t'(command);
                    target_next = (cmd_t'(command) == CMD_INS_AFTER) ? key : value;
                    carry_next  = value;
                    found_next  = (cmd_t'(command) == CMD_INS_FRONT);
                    rd_ptr_next = '0;
                    if (((cmd_t'(command) == CMD_INS_FRONT) ||
                         (cmd_t'(command) == CMD_INS_AFTER)) &&
                        (count_reg == CW'(CAPACITY)))
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_RESULT;
                    end
                    else if ((cmd_t'(command) == CMD_DUMP) && (count_reg == '0))
                    begin
                        rstat_next = ST_EMPTY;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                dv_next = issue || hold;
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                    dp_next     = rd_ptr_reg[AW-1:0];
                end
                if (dv_reg)
                begin
                    case (cmd_reg)
                        CMD_DUMP:
                        begin
                            res_valid = 1'b1;
                            res = '{status: ST_ELEMENT, element: mem_rdata,
                                    position: 6'(dp_reg),
                                    entry_count: 7'(count_reg),
                                    last: ((CW'(dp_reg) + CW'(1)) == count_reg)};
                        end
                        CMD_DELETE:
                        begin
                            // after the match every entry moves one toward the front
                            if (found_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = dp_reg - AW'(1);
                                mem_wdata = mem_rdata;
                            end
                            else if (hit)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // after the match the carry ripples each entry back one
                            if (found_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = dp_reg;
                                mem_wdata  = carry_reg;
                                carry_next = mem_rdata;
                            end
                            else if (hit)
                            begin
                                found_next = 1'b1;
                            end
                        end
                    endcase
                end
                if ((rd_ptr_reg == count_reg) && !dv_reg)
                begin
                    state_next = (cmd_reg == CMD_DUMP) ? S_IDLE : S_FINISH;
                end
            end

            S_FINISH:
            begin
                state_next = S_RESULT;
                if (found_reg)
                begin
                    rstat_next = ST_DONE;
                    if (is_ins)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = carry_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    rstat_next = ST_NOT_FOUND;
                end
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/ordered_value_list_core.sv
// Ordered value list: ordered store of signed 32-bit values under four commands.
//
// Input channel (in_valid/in_stall, fields command/key/value) takes one
// transaction at a time; in_stall stays high until the command has handed its
// results to the output register. Commands: insert at front, insert after the
// first entry equal to key, delete the first entry equal to value, dump.
// Output channel (out_valid/out_stall) carries status, element, position,
// entry_count and last. Dump gives one transaction per entry, last on the
// final one; an empty dump and every other command give a single transaction.
// A command makes one pass through the entry memory, one read per cycle
// through its single read port while no dump result is held up at the
// output. Inserts into a full list and dumps of an empty list answer
// without a pass over the memory. A one-deep output register lets the
// sequencer finish while the receiver stalls; dump progress freezes while
// that register stays full.
// Reset empties the list and clears all handshake state; entry storage is
// not cleared, since only positions below the count are ever read.
module ordered_value_list_core #(
    parameter int CAPACITY = ovl_pkg::OVL_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] element,
    output logic [5:0]         position,
    output logic [6:0]         entry_count,
    output logic               last
);
    import ovl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          res_valid;
    logic          res_ready;
    res_t          res;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;

    ovl_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ovl_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .key       (key),
        .value     (value),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign element     = out_res_reg.element;
    assign position    = out_res_reg.position;
    assign entry_count = out_res_reg.entry_count;
    assign last        = out_res_reg.last;

endmodule

### rtl/ovl_checker.sv
// Port-level checks for the ordered value list, bound to the top level.
`include "ordered_value_list_core_assert.svh"

module ovl_checker #(
    parameter int CAPACITY = ovl_pkg::OVL_CAPACITY
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         status,
    input logic signed [31:0] element,
    input logic [5:0]         position,
    input logic [6:0]         entry_count,
    input logic               last
);
    import ovl_pkg::*;

    `OVL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(element) && $stable(status) && $stable(last))
    `OVL_ASSERT_IMPL(a_single_last, clk, rst_n, out_valid && (status != ST_ELEMENT),
        last && (element == 32'sd0))
    `OVL_ASSERT_IMPL(a_count_bound, clk, rst_n, out_valid,
        entry_count <= 7'(CAPACITY))
    `OVL_ASSERT_IMPL(a_pos_in_list, clk, rst_n, out_valid && (status == ST_ELEMENT),
        (7'(position) < entry_count) && (last == (7'(position) + 7'd1 == entry_count)))
    `OVL_ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && (status == ST_EMPTY),
        entry_count == 7'd0)

endmodule

bind ordered_value_list_core ovl_checker #(
    .CAPACITY (CAPACITY)
) u_ovl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .element     (element),
    .position    (position),
    .entry_count (entry_count),
    .last        (last)
);

### bench/tb_top.sv
// Self-checking bench for ordered_value_list_core: directed table, then random list traffic.
module tb_top;
    import ovl_pkg::*;

    localparam int LIST_CAP = OVL_CAPACITY;
    localparam int NUM_DIR = 25;
    localparam int RANDOM_ITEMS = 190;

    typedef struct {
        cmd_t               op;
        logic signed [31:0] k;
        logic signed [31:0] v;
        bit                 typed;
        status_t            tst;
        logic [6:0]         tcnt;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = '0;
    logic signed [31:0] key = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [5:0]         position;
    logic [6:0]         entry_count;
    logic               last;

    // shadow copy of the list, front at index 0
    logic signed [31:0] model_list[$];
    res_t               predicted_batch[$];
    res_t               awaited_results[$];
    plan_row_t          directed_plan [NUM_DIR];

    int idle_pct = 10;
    int mismatch_count = 0;
    int results_checked = 0;
    int sent_count = 0;
    int full_refusals = 0;
    int peak_len = 0;
    int cmd_seen [4] = '{0, 0, 0, 0};

    ordered_value_list_core #(.CAPACITY(LIST_CAP)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .key(key),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .element(element),
        .position(position),
        .entry_count(entry_count),
        .last(last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void note_result(status_t st, logic signed [31:0] el, int pos, bit lst);
        res_t r;
        r.status = st;
        r.element = el;
        r.position = pos[5:0];
        r.entry_count = 7'(model_list.size());
        r.last = lst;
        predicted_batch.push_back(r);
    endfunction

    function automatic int find_entry(logic signed [31:0] x);
        for (int i = 0; i < model_list.size(); i++)
        begin
            if (model_list[i] == x)
                return i;
        end
        return -1;
    endfunction

    // Applies one command to the shadow list and fills predicted_batch.
    function automatic void step_list_model(cmd_t op, logic signed [31:0] k,
                                            logic signed [31:0] v);
        int hit;
        predicted_batch.delete();
        case (op)
            CMD_INS_FRONT:
            begin
                if (model_list.size() >= LIST_CAP)
                    note_result(ST_FULL, 0, 0, 1'b1);
                else
                begin
                    model_list.push_front(v);
                    note_result(ST_DONE, 0, 0, 1'b1);
                end
            end
            CMD_INS_AFTER:
            begin
                // full check wins over the key search
                if (model_list.size() >= LIST_CAP)
                    note_result(ST_FULL, 0, 0, 1'b1);
                else
                begin
                    hit = find_entry(k);
                    if (hit < 0)
                        note_result(ST_NOT_FOUND, 0, 0, 1'b1);
                    else
                    begin
                        if (hit + 1 == model_list.size())
                            model_list.push_back(v);
                        else
                            model_list.insert(hit + 1, v);
                        note_result(ST_DONE, 0, 0, 1'b1);
                    end
                end
            end
            CMD_DELETE:
            begin
                hit = find_entry(v);
                if (hit < 0)
                    note_result(ST_NOT_FOUND, 0, 0, 1'b1);
                else
                begin
                    model_list.delete(hit);
                    note_result(ST_DONE, 0, 0, 1'b1);
                end
            end
            default:
            begin
                if (model_list.size() == 0)
                    note_result(ST_EMPTY, 0, 0, 1'b1);
                else
                begin
                    for (int i = 0; i < model_list.size(); i++)
                        note_result(ST_ELEMENT, model_list[i], i, i + 1 == model_list.size());
                end
            end
        endcase
    endfunction

    // hit_pct: chance of reusing a value already in the list
    function automatic logic signed [31:0] pick_value(int hit_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (model_list.size() > 0 && roll < hit_pct)
            return model_list[$urandom_range(0, model_list.size() - 1)];
        if (roll < hit_pct + 20)
            return $signed($urandom_range(0, 6)) - 3;
        return $urandom;
    endfunction

    task automatic issue_command(cmd_t op, logic signed [31:0] k, logic signed [31:0] v,
                                 bit typed, status_t tst, logic [6:0] tcnt);
        res_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= op;
        key <= k;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transaction taken at this edge
        step_list_model(op, k, v);
        if (typed)
        begin
            r.status = tst;
            r.element = '0;
            r.position = '0;
            r.entry_count = tcnt;
            r.last = 1'b1;
            awaited_results.push_back(r);
        end
        else
        begin
            foreach (predicted_batch[i])
                awaited_results.push_back(predicted_batch[i]);
        end
        if (predicted_batch[0].status == ST_FULL)
            full_refusals++;
        if (model_list.size() > peak_len)
            peak_len = model_list.size();
        cmd_seen[op]++;
        sent_count++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    function automatic void compare_field(string name, logic signed [32:0] want,
                                          logic signed [32:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t: unexpected result, expected none, got status %0d element %0d",
                             $time, status, element);
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("status", 33'(want.status), 33'(status));
                compare_field("element", 33'(want.element), 33'(element));
                compare_field("position", 33'(want.position), 33'(position));
                compare_field("entry_count", 33'(want.entry_count), 33'(entry_count));
                compare_field("last", 33'(want.last), 33'(last));
            end
        end
    end

    initial
    begin
        int n;
        int kind;
        cmd_t op;

        directed_plan = '{
            '{CMD_DUMP,      32'sh0,        32'sh0,        1'b1, ST_EMPTY,     7'd0},
            '{CMD_DELETE,    32'sh0,        32'sh5,        1'b1, ST_NOT_FOUND, 7'd0},
            '{CMD_INS_AFTER, 32'sh0,        32'sh1,        1'b1, ST_NOT_FOUND, 7'd0},
            '{CMD_INS_FRONT, 32'shFFFFFFFF, 32'sh7FFFFFFF, 1'b1, ST_DONE,      7'd1},
            '{CMD_INS_FRONT, 32'sh0,        32'sh80000000, 1'b1, ST_DONE,      7'd2},
            '{CMD_INS_AFTER, 32'sh7FFFFFFF, 32'shFFFFFFFF, 1'b1, ST_DONE,      7'd3},
            '{CMD_INS_AFTER, 32'sh3039,     32'sh0,        1'b1, ST_NOT_FOUND, 7'd3},
            '{CMD_INS_FRONT, 32'sh55555555, 32'shAAAAAAAA, 1'b1, ST_DONE,      7'd4},
            '{CMD_INS_AFTER, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, ST_DONE,      7'd5},
            '{CMD_DUMP,      32'shAAAAAAAA, 32'sh55555555, 1'b0, ST_DONE,      7'd0},
            // duplicates: the one nearest the front goes
            '{CMD_DELETE,    32'sh0,        32'sh7FFFFFFF, 1'b1, ST_DONE,      7'd4},
            '{CMD_INS_AFTER, 32'shFFFFFFFF, 32'sh55555555, 1'b0, ST_DONE,      7'd0},
            '{CMD_INS_FRONT, 32'sh0,        32'sh55555555, 1'b0, ST_DONE,      7'd0},
            '{CMD_INS_AFTER, 32'sh55555555, 32'sh0,        1'b0, ST_DONE,      7'd0},
            '{CMD_DUMP,      32'sh0,        32'sh0,        1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh0,        32'sh55555555, 1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh0,        32'sh80000000, 1'b1, ST_DONE,      7'd5},
            '{CMD_DELETE,    32'sh0,        32'sh80000000, 1'b1, ST_NOT_FOUND, 7'd5},
            '{CMD_DUMP,      32'sh0,        32'sh0,        1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh55555555, 32'shAAAAAAAA, 1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh0,        32'sh0,        1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh0,        32'sh7FFFFFFF, 1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh0,        32'shFFFFFFFF, 1'b0, ST_DONE,      7'd0},
            '{CMD_DELETE,    32'sh0,        32'sh55555555, 1'b1, ST_DONE,      7'd0},
            '{CMD_DUMP,      32'sh0,        32'sh0,        1'b1, ST_EMPTY,     7'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
            issue_command(directed_plan[i].op, directed_plan[i].k, directed_plan[i].v,
                          directed_plan[i].typed, directed_plan[i].tst, directed_plan[i].tcnt);
        wait_for_results();

        for (int ep = 0; sent_count < NUM_DIR + RANDOM_ITEMS; ep++)
        begin
            idle_pct = (ep == 2) ? 0 : 10;
            kind = (ep == 0) ? 0 : $urandom_range(0, 2);
            case (kind)
                0:
                begin
                    // fill to capacity, poke at the full list, then dump it
                    while (model_list.size() < LIST_CAP)
                    begin
                        if (model_list.size() > 0 && $urandom_range(0, 3) != 0)
                            issue_command(CMD_INS_AFTER, pick_value(85), pick_value(30),
                                          1'b0, ST_DONE, 0);
                        else
                            issue_command(CMD_INS_FRONT, $urandom, pick_value(30),
                                          1'b0, ST_DONE, 0);
                    end
                    issue_command(CMD_INS_FRONT, $urandom, $urandom, 1'b0, ST_DONE, 0);
                    issue_command(CMD_INS_AFTER, pick_value(100), $urandom, 1'b0, ST_DONE, 0);
                    issue_command(CMD_INS_AFTER, $urandom, $urandom, 1'b0, ST_DONE, 0);
                    issue_command(CMD_DUMP, $urandom, $urandom, 1'b0, ST_DONE, 0);
                    if (ep == 0)
                        wait_for_results();
                end
                1:
                begin
                    n = $urandom_range(10, 20);
                    repeat (n)
                    begin
                        op = cmd_t'($urandom_range(0, 3));
                        issue_command(op, pick_value(60), pick_value(40), 1'b0, ST_DONE, 0);
                    end
                end
                default:
                begin
                    n = $urandom_range(4, 12);
                    repeat (n)
                        issue_command(CMD_DELETE, $urandom, pick_value(80), 1'b0, ST_DONE, 0);
                    issue_command(CMD_DUMP, $urandom, $urandom, 1'b0, ST_DONE, 0);
                end
            endcase
        end

        idle_pct = 10;
        wait_for_results();
        repeat (2 * LIST_CAP + 8) @(posedge clk);

        $display("Sent %0d commands: %0d front, %0d after, %0d delete, %0d dump; peak length %0d.",
                 sent_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], peak_len);
        $display("Checked %0d result transactions, %0d inserts refused on a full list.",
                 results_checked, full_refusals);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
